/* hw/rtl/mpqd_pkg.sv */
// ----------------------------------------------------------------------------
// mpqd_pkg
// Shared types, constants and functions of the word stream decryptor.
// ----------------------------------------------------------------------------
package mpqd_pkg;

  localparam int WORD_W      = 32;
  localparam int TABLE_WORDS = 256;
  localparam int ROM_AW      = $clog2(TABLE_WORDS);

  localparam logic [WORD_W-1:0] GEN_START = 32'h0010_0001;
  localparam logic [WORD_W-1:0] GEN_MUL   = 32'd125;
  localparam logic [WORD_W-1:0] GEN_MOD   = 32'h002A_AAAB;
  localparam logic [WORD_W-1:0] SEED_INIT = 32'hEEEE_EEEE;
  localparam logic [WORD_W-1:0] KEY_ADD   = 32'h1111_1111;
  localparam int                KEY_SHL   = 'h15;
  localparam int                KEY_SHR   = 'h0B;
  localparam int                GEN_COLS  = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROM_AW-1:0] rom_addr_t;
  typedef logic [TABLE_WORDS-1:0][WORD_W-1:0] rom_t;

  typedef struct packed {
    word_t cipher_word;
    logic  block_start;
    word_t block_key;
    logic  block_last;
  } cipher_t;

  typedef struct packed {
    word_t plain_word;
    logic  last;
  } plain_t;

  // Contents of the register between the key stage and the seed stage.
  typedef struct packed {
    logic  valid;
    word_t cipher_word;
    word_t key;
    logic  start;
    logic  last;
  } stage_t;

  // One step of the table generator; the state always stays below GEN_MOD,
  // so the product fits in 32 bits.
  function automatic word_t gen_next(input word_t s);
    return (s * GEN_MUL + 32'd3) % GEN_MOD;
  endfunction

  // Builds the generated crypt table at elaboration.
  function automatic rom_t build_rom();
    rom_t  t;
    word_t s;
    word_t hi;
    t = '0;
    s = GEN_START;
    for (int row = 0; row < TABLE_WORDS; row++) begin
      for (int col = 0; col < GEN_COLS; col++) begin
        s  = gen_next(s);
        hi = {s[15:0], 16'h0000};
        s  = gen_next(s);
        if (col == GEN_COLS - 1) begin
          t[row] = hi | {16'h0000, s[15:0]};
        end
      end
    end
    return t;
  endfunction

  function automatic word_t key_step(input word_t k);
    return ((~k << KEY_SHL) + KEY_ADD) | (k >> KEY_SHR);
  endfunction

endpackage

/* hw/rtl/mpqd_rom.sv */
// ----------------------------------------------------------------------------
// mpqd_rom
// Synchronous crypt table ROM with read enable and a registered read port.
// ----------------------------------------------------------------------------
module mpqd_rom
  import mpqd_pkg::*;
(
  input  logic      clk,
  input  logic      rd_en,
  input  rom_addr_t rd_addr,
  output word_t     rd_data
);

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ROM[rd_addr];
    end
  end

endmodule

/* hw/rtl/mpqd_key_stage.sv */
// ----------------------------------------------------------------------------
// mpqd_key_stage
// Input stage: selects the key for each word, starts the table read and
// advances the running key.
// ----------------------------------------------------------------------------
module mpqd_key_stage
  import mpqd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cipher_t   in_data,
  input  logic      next_ready,
  output logic      rom_en,
  output rom_addr_t rom_addr,
  output stage_t    stage
);

  word_t key;
  word_t key_sel;
  logic  accept;

  assign in_ready = !stage.valid || next_ready;
  assign accept   = in_valid && in_ready;
  assign key_sel  = in_data.block_start ? in_data.block_key : key;
  assign rom_en   = accept;
  assign rom_addr = key_sel[ROM_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        key         <= key_step(key_sel);
        stage.valid <= 1'b1;
      end else if (next_ready) begin
        stage.valid <= 1'b0;
      end
    end
    if (accept) begin
      stage.cipher_word <= in_data.cipher_word;
      stage.key         <= key_sel;
      stage.start       <= in_data.block_start;
      stage.last        <= in_data.block_last;
    end
  end

`ifndef SYNTHESIS
  a_key_load: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.block_start |=> key == key_step($past(in_data.block_key)))
    else $error("running key not loaded from the block key");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !next_ready |=> stage.valid && $stable(stage.cipher_word)
      && $stable(stage.key))
    else $error("stalled stage lost its word");

  a_stage_reset: assert property (@(posedge clk)
    rst |=> !stage.valid)
    else $error("stage valid after reset");
`endif

endmodule

/* hw/rtl/mpqd_seed_stage.sv */
// ----------------------------------------------------------------------------
// mpqd_seed_stage
// Second stage: adds the table word to the running seed, decrypts the word,
// updates the seed and holds the result in the output register.
// ----------------------------------------------------------------------------
module mpqd_seed_stage
  import mpqd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  stage_t stage,
  input  word_t  rom_data,
  output logic   stage_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output plain_t out_data
);

  word_t seed;
  word_t seed_base;
  word_t seed_sum;
  word_t plain;
  word_t seed_next;
  logic  advance;

  assign stage_ready = !out_valid || out_ready;
  assign advance     = stage.valid && stage_ready;

  // A block start restarts the seed, so the stored seed is bypassed.
  assign seed_base = stage.start ? SEED_INIT : seed;
  assign seed_sum  = seed_base + rom_data;
  assign plain     = stage.cipher_word ^ (stage.key + seed_sum);
  assign seed_next = plain + seed_sum + (seed_sum << 5) + 32'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_INIT;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        seed      <= seed_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.plain_word <= plain;
      out_data.last       <= stage.last;
    end
  end

`ifndef SYNTHESIS
  a_seed_reset: assert property (@(posedge clk)
    rst |=> seed == SEED_INIT)
    else $error("seed not restored by reset");

  a_seed_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(seed))
    else $error("seed changed without a word");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("decrypted word not presented");
`endif

endmodule

/* hw/rtl/table_keyed_word_stream_decrypt_unit.sv */
// ----------------------------------------------------------------------------
// table_keyed_word_stream_decrypt_unit
// Stream decryptor for table keyed 32-bit words.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while the output is not stalled, and
// returns one decrypted word for each, in order, through the stage and output
// registers. The first stage selects the key (block key on a block start,
// otherwise the running key) and reads the crypt table ROM at its low byte;
// the second adds the table word to the seed, decrypts and updates the seed.
// The running key advances in the first stage and the seed in the second, so
// consecutive words need no interlock. An output register parts the output
// from the pipeline; back pressure stalls the seed stage and a full key stage.
module table_keyed_word_stream_decrypt_unit
  import mpqd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cipher_valid,
  output logic    cipher_ready,
  input  cipher_t cipher,
  output logic    plain_valid,
  input  logic    plain_ready,
  output plain_t  plain
);

  stage_t    stage;
  logic      stage_ready;
  logic      rom_en;
  rom_addr_t rom_addr;
  word_t     rom_data;

  mpqd_key_stage u_key_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cipher_valid),
    .in_ready   (cipher_ready),
    .in_data    (cipher),
    .next_ready (stage_ready),
    .rom_en     (rom_en),
    .rom_addr   (rom_addr),
    .stage      (stage)
  );

  mpqd_rom u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  mpqd_seed_stage u_seed_stage (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .rom_data    (rom_data),
    .stage_ready (stage_ready),
    .out_valid   (plain_valid),
    .out_ready   (plain_ready),
    .out_data    (plain)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the table keyed word stream decryptor. Words are
// streamed through the valid/ready channels under several idling patterns,
// and every decrypted word is checked against an independent prediction of
// the key and seed recurrences.
// ----------------------------------------------------------------------------
module testbench
  import mpqd_pkg::*;
();

  localparam int          ROM_SIZE      = 256;
  localparam int unsigned LCG_SEED      = 32'h0010_0001;
  localparam int unsigned LCG_MUL       = 125;
  localparam int unsigned LCG_MOD       = 32'h002A_AAAB;
  localparam int          LCG_COLUMNS   = 5;
  localparam word_t       SEED_RESET    = 32'hEEEE_EEEE;
  localparam word_t       KEY_MIX       = 32'h1111_1111;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          WATCHDOG_MAX  = 1000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          PHASE_WORDS   = 260;
  localparam int          PHASES        = 4;

  class plain_scoreboard;
    word_t       crypt_words [ROM_SIZE];
    word_t       key_reg;
    word_t       seed_reg;
    plain_t      pending_plain [$];
    int unsigned mismatches;

    function new();
      int unsigned lcg;
      word_t       upper;
      lcg = LCG_SEED;
      for (int r = 0; r < ROM_SIZE; r++) begin
        for (int e = 0; e < LCG_COLUMNS; e++) begin
          lcg   = (lcg * LCG_MUL + 3) % LCG_MOD;
          upper = {lcg[15:0], 16'h0000};
          lcg   = (lcg * LCG_MUL + 3) % LCG_MOD;
          // Only the last column of each row is kept in the table.
          if (e == LCG_COLUMNS - 1) begin
            crypt_words[r] = upper | {16'h0000, lcg[15:0]};
          end
        end
      end
      key_reg    = '0;
      seed_reg   = SEED_RESET;
      mismatches = 0;
    endfunction

    // Advances the key and seed over one accepted word and queues its result.
    function void note_cipher(input cipher_t c);
      word_t  mixed_seed;
      plain_t result;
      if (c.block_start) begin
        key_reg  = c.block_key;
        seed_reg = SEED_RESET;
      end
      mixed_seed        = seed_reg + crypt_words[key_reg[7:0]];
      result.plain_word = c.cipher_word ^ (key_reg + mixed_seed);
      result.last       = c.block_last;
      key_reg           = ((~key_reg << 21) + KEY_MIX) | (key_reg >> 11);
      seed_reg          = result.plain_word + mixed_seed + (mixed_seed << 5) + 32'd3;
      pending_plain.push_back(result);
    endfunction

    function void check_plain(input plain_t p);
      plain_t want;
      if (pending_plain.size() == 0) begin
        $error("plain transfer %h/%b with no word outstanding", p.plain_word, p.last);
        mismatches++;
        return;
      end
      want = pending_plain.pop_front();
      if (p.plain_word !== want.plain_word) begin
        $error("plain_word: expected %h, got %h", want.plain_word, p.plain_word);
        mismatches++;
      end
      if (p.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, p.last);
        mismatches++;
      end
    endfunction

    function void check_drained();
      plain_t lost;
      while (pending_plain.size() != 0) begin
        lost = pending_plain.pop_front();
        $error("plain_word %h never delivered", lost.plain_word);
        mismatches++;
      end
    endfunction
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    cipher_valid = 1'b0;
  logic    cipher_ready;
  cipher_t cipher       = '0;
  logic    plain_valid;
  logic    plain_ready  = 1'b0;
  plain_t  plain;

  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  bit      hold_request  = 1'b0;
  int      quiet_cycles  = 0;

  plain_scoreboard plain_sb = new();

  table_keyed_word_stream_decrypt_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher),
    .plain_valid  (plain_valid),
    .plain_ready  (plain_ready),
    .plain        (plain)
  );

  always #6 clk = ~clk;

  function automatic cipher_t word_item(input word_t cw, input logic start,
                                        input word_t key, input logic last);
    cipher_t c;
    c.cipher_word = cw;
    c.block_start = start;
    c.block_key   = key;
    c.block_last  = last;
    return c;
  endfunction

  // Valid is lowered only when an idle gap is taken, so back-to-back words
  // keep it high across the transfer edge.
  task automatic send_cipher(input cipher_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cipher_valid <= 1'b0;
      @(posedge clk);
    end
    cipher_valid <= 1'b1;
    cipher       <= c;
    @(posedge clk);
    while (!cipher_ready) @(posedge clk);
    plain_sb.note_cipher(c);
  endtask

  // Mostly well-formed blocks with random keys and lengths; the rest are
  // short runs with random start and last flags.
  task automatic send_random_words(input int count);
    int sent;
    int len;
    cipher_t c;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          c = word_item($urandom, (i == 0), $urandom, (i == len - 1));
          send_cipher(c);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          c = word_item($urandom, 1'($urandom_range(1)), $urandom,
                        1'($urandom_range(1)));
          send_cipher(c);
        end
      end
      sent += len;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        plain_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      plain_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && plain_valid && plain_ready) begin
      plain_sb.check_plain(plain);
    end
  end

  always @(posedge clk) begin
    if ((cipher_valid && cipher_ready) || (plain_valid && plain_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int idle_plan [PHASES];
    int stall_plan [PHASES];
    idle_plan  = '{0, 56, 0, 8};
    stall_plan = '{0, 0, 56, 8};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Words ahead of any block start run on the reset key and seed.
    send_cipher(word_item(32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b0));
    send_cipher(word_item(32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0));
    send_cipher(word_item(32'hA5A5_A5A5, 1'b0, 32'h1234_5678, 1'b1));
    send_cipher(word_item(32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0));
    send_cipher(word_item(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0));
    send_cipher(word_item(32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1));
    // The key stream carries on past a last flag.
    send_cipher(word_item(32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0));
    send_cipher(word_item(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_cipher(word_item(32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0));
    send_cipher(word_item(32'hDEAD_BEEF, 1'b0, 32'hCAFE_F00D, 1'b0));
    // A new start abandons the block still running.
    send_cipher(word_item(32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0));
    send_cipher(word_item(32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0));
    send_cipher(word_item(32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 1'b0));
    send_cipher(word_item(32'hAAAA_AAAA, 1'b0, 32'h5555_5555, 1'b1));
    send_cipher(word_item(32'h0000_0000, 1'b1, 32'h0000_00FF, 1'b1));
    send_cipher(word_item(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF00, 1'b0));
    send_cipher(word_item(32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b0));
    send_cipher(word_item(32'h0000_0001, 1'b0, 32'h0000_0000, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct     = stall_plan[ph];
      // In the first phase the receiver holds off while words keep coming,
      // so the pipeline fills and stalls its input.
      if (ph == 0) begin
        hold_request = 1'b1;
      end
      send_random_words(PHASE_WORDS);
    end
    cipher_valid <= 1'b0;

    while (plain_sb.pending_plain.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    plain_sb.check_drained();

    if (plain_sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
